### hw/rtl/b64c_pkg.sv
// ----------------------------------------------------------------------------
// b64c_pkg
// Shared types, character constants and alphabet functions of the base64 codec.
// ----------------------------------------------------------------------------
`default_nettype none

package b64c_pkg;

  localparam logic [7:0] PadChar   = 8'h3D;
  localparam logic [7:0] PlusChar  = 8'h2B;
  localparam logic [7:0] SlashChar = 8'h2F;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // One completed group: up to four result words, first word in data[0].
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [2:0]      count;
    logic            last;
    logic            err;
  } grp_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] c;
    case (v) inside
      [6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
      [6'd26:6'd51]: c = 8'h47 + {2'b00, v};
      [6'd52:6'd61]: c = {2'b00, v} - 8'h04;
      6'd62:         c = PlusChar;
      default:       c = SlashChar;
    endcase
    return c;
  endfunction

  function automatic logic [5:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] t;
    case (c) inside
      [8'h41:8'h5A]: t = c - 8'h41;
      [8'h61:8'h7A]: t = c - 8'h47;
      [8'h30:8'h39]: t = c + 8'h04;
      PlusChar:      t = 8'd62;
      SlashChar:     t = 8'd63;
      default:       t = 8'd0;
    endcase
    return t[5:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/b64c_gather.sv
// ----------------------------------------------------------------------------
// b64c_gather
// Holds the mode and the group being gathered, and forms the result group.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_gather (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    data_i,
  input  logic          last_i,
  output logic          grp_valid_o,
  input  logic          grp_ready_i,
  output b64c_pkg::grp_t grp_o
);
  import b64c_pkg::*;

  logic        mode_q, mode_d;
  logic [23:0] bits_q, bits_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        pad3_q, pad3_d;

  logic [1:0]  cnt_enc;
  logic [5:0]  sextet;
  logic [23:0] enc_bits;
  logic [23:0] dec_bits;
  logic [1:0]  pads;
  logic [1:0]  drops;
  logic        complete;
  logic        accept;

  assign cnt_enc  = (cnt_q == 2'd3) ? 2'd2 : cnt_q;
  assign sextet   = char_to_sextet(data_i);
  assign complete = (mode_q == ModeDecode) ? ((cnt_q == 2'd3) || last_i)
                                           : ((cnt_enc == 2'd2) || last_i);
  assign in_ready_o  = !complete || grp_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign grp_valid_o = in_valid_i && complete;

  always_comb begin
    case (cnt_enc)
      2'd0:    enc_bits = bits_q | {data_i, 16'h0000};
      2'd1:    enc_bits = bits_q | {8'h00, data_i, 8'h00};
      default: enc_bits = bits_q | {16'h0000, data_i};
    endcase
    case (cnt_q)
      2'd0:    dec_bits = bits_q | {sextet, 18'h00000};
      2'd1:    dec_bits = bits_q | {6'h00, sextet, 12'h000};
      2'd2:    dec_bits = bits_q | {12'h000, sextet, 6'h00};
      default: dec_bits = bits_q | {18'h00000, sextet};
    endcase
  end

  always_comb begin
    case (cnt_enc)
      2'd0:    pads = 2'd2;
      2'd1:    pads = 2'd1;
      default: pads = 2'd0;
    endcase
    drops = {1'b0, last_i && (data_i == PadChar)} + {1'b0, last_i && pad3_q};
  end

  always_comb begin
    grp_o = '0;
    if (mode_q == ModeEncode) begin
      grp_o.data[0] = sextet_to_char(enc_bits[23:18]);
      grp_o.data[1] = sextet_to_char(enc_bits[17:12]);
      grp_o.data[2] = (pads == 2'd2) ? PadChar : sextet_to_char(enc_bits[11:6]);
      grp_o.data[3] = (pads != 2'd0) ? PadChar : sextet_to_char(enc_bits[5:0]);
      grp_o.count   = 3'd4;
      grp_o.last    = last_i;
    end else if (cnt_q != 2'd3) begin
      grp_o.count = 3'd1;
      grp_o.last  = 1'b1;
      grp_o.err   = 1'b1;
    end else begin
      grp_o.data[0] = dec_bits[23:16];
      grp_o.data[1] = dec_bits[15:8];
      grp_o.data[2] = dec_bits[7:0];
      grp_o.count   = 3'd3 - {1'b0, drops};
      grp_o.last    = last_i;
    end
  end

  always_comb begin
    mode_d = mode_q;
    bits_d = bits_q;
    cnt_d  = cnt_q;
    pad3_d = pad3_q;
    if (cfg_we_i) begin
      mode_d = cfg_wdata_i;
      bits_d = '0;
      cnt_d  = '0;
      pad3_d = 1'b0;
    end else if (accept) begin
      if (complete) begin
        bits_d = '0;
        cnt_d  = '0;
        pad3_d = 1'b0;
      end else if (mode_q == ModeEncode) begin
        bits_d = enc_bits;
        cnt_d  = cnt_enc + 2'd1;
      end else begin
        bits_d = dec_bits;
        cnt_d  = cnt_q + 2'd1;
        if ((cnt_q == 2'd2) && (data_i == PadChar)) begin
          pad3_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeEncode;
      bits_q <= '0;
      cnt_q  <= '0;
      pad3_q <= 1'b0;
    end else begin
      mode_q <= mode_d;
      bits_q <= bits_d;
      cnt_q  <= cnt_d;
      pad3_q <= pad3_d;
    end
  end

  a_cfg_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> (cnt_q == 2'd0) && (bits_q == 24'h000000) && !pad3_q)
    else $error("configuration write did not clear the partial group");

  a_enc_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == ModeEncode) |-> (cnt_q != 2'd3))
    else $error("encode group count out of range");

  a_pad3_decode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad3_q |-> (mode_q == ModeDecode))
    else $error("third-position pad flag set outside decode mode");

endmodule

`default_nettype wire

### hw/rtl/b64c_emit.sv
// ----------------------------------------------------------------------------
// b64c_emit
// Result register that hands out a completed group one word per cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module b64c_emit (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           grp_valid_i,
  output logic           grp_ready_o,
  input  b64c_pkg::grp_t grp_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     data_res_o,
  output logic           last_res_o,
  output logic           error_o
);
  import b64c_pkg::*;

  logic            busy_q, busy_d;
  logic [2:0]      rem_q, rem_d;
  logic [3:0][7:0] buf_q, buf_d;
  logic            last_q, last_d;
  logic            err_q, err_d;
  logic            pop;
  logic            load;

  assign pop         = busy_q && out_ready_i;
  assign grp_ready_o = !busy_q || (pop && (rem_q == 3'd1));
  assign load        = grp_valid_i && grp_ready_o;

  assign out_valid_o = busy_q;
  assign data_res_o  = buf_q[0];
  assign last_res_o  = last_q && (rem_q == 3'd1);
  assign error_o     = err_q;

  always_comb begin
    busy_d = busy_q;
    rem_d  = rem_q;
    buf_d  = buf_q;
    last_d = last_q;
    err_d  = err_q;
    if (load) begin
      busy_d = 1'b1;
      rem_d  = grp_i.count;
      buf_d  = grp_i.data;
      last_d = grp_i.last;
      err_d  = grp_i.err;
    end else if (pop) begin
      busy_d = (rem_q != 3'd1);
      rem_d  = rem_q - 3'd1;
      buf_d  = {8'h00, buf_q[3:1]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rem_q  <= '0;
    end else begin
      busy_q <= busy_d;
      rem_q  <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q  <= buf_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q != 3'd0) && (rem_q <= 3'd4))
    else $error("remaining word count out of range while busy");

  a_pop_stays: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && (rem_q != 3'd1)) |=> busy_q)
    else $error("group dropped before its last word was taken");

  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> busy_q && (rem_q == $past(grp_i.count)))
    else $error("group load did not take its word count");

endmodule

`default_nettype wire

### hw/rtl/base64_codec.sv
// ----------------------------------------------------------------------------
// base64_codec
// Base64 encoder and decoder with a mode register and valid/ready channels.
// ----------------------------------------------------------------------------
// Write cfg_wdata_i with cfg_we_i while the block is idle: 0 selects encoding
// of raw bytes, 1 selects decoding of characters. A write clears any partial
// group. Input words carry data_i and last_i; last_i marks the end of a message.
// Encoding turns each three bytes, or a shorter final group, into four
// characters with '=' padding. Decoding turns four characters into up to three
// bytes; a message that ends inside a group yields one word with error_o set.
// A word that completes a group appears on the output in the cycle after it is
// accepted, and the group then leaves at one word per cycle while the receiver
// is ready. Words that only add to a group are taken every cycle; a completing
// word waits while the result register still holds more than its last word, so
// the output side sets the sustained flow. If the receiver stalls, the result
// register holds its word and input stops at the next completing word. Reset
// selects encoding, clears the group and empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_codec (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_i,
  input  logic       last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_res_o,
  output logic       last_res_o,
  output logic       error_o
);
  import b64c_pkg::*;

  grp_t grp;
  logic grp_valid;
  logic grp_ready;

  b64c_gather u_gather (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_i      (data_i),
    .last_i      (last_i),
    .grp_valid_o (grp_valid),
    .grp_ready_i (grp_ready),
    .grp_o       (grp)
  );

  b64c_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .grp_valid_i (grp_valid),
    .grp_ready_o (grp_ready),
    .grp_i       (grp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .data_res_o  (data_res_o),
    .last_res_o  (last_res_o),
    .error_o     (error_o)
  );

endmodule

`default_nettype wire

### verif/base64_codec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_codec_test
// Self-checking testbench for the base64 encoder and decoder.
// ----------------------------------------------------------------------------
// A directed table covers short and full groups, the all-zero and all-one
// extremes, padding, characters outside the alphabet, mode writes that drop a
// partial group and a decode message that ends inside a group. Random phases
// then switch the mode and send encode messages and mostly well-formed decode
// messages, with random gaps on the input and random stalls on the output.
// Every result word is checked against the table's expectation or a predictor kept in step with the block.
// ----------------------------------------------------------------------------

module base64_codec_test;
  import b64c_pkg::*;

  localparam int QuietLimit = 2000;
  localparam int RandomWords = 200;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       err;
  } res_word_t;

  typedef struct packed {
    logic [2:0]           n;
    res_word_t [3:0]      w;
  } res_set_t;

  typedef enum logic {
    RowWord,
    RowCfg
  } row_kind_e;

  typedef struct packed {
    row_kind_e  kind;
    logic       typed;
    logic [7:0] data;
    logic       last;
    res_set_t   want;
  } stim_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_i = 8'h00;
  logic       last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] data_res_o;
  logic       last_res_o;
  logic       error_o;

  // Predictor state.
  logic        cur_mode = ModeEncode;
  logic [23:0] grp_bits = '0;
  logic [1:0]  grp_cnt = '0;
  logic        pad_3rd = 1'b0;

  res_word_t   exp_q[$];
  res_word_t   mon_want;
  stim_row_t   dir_tab[$];

  bit          calm = 1'b0;
  int          ready_hold;
  int unsigned quiet_cycles = 0;
  int unsigned fail_count = 0;
  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_cfg = 0;

  base64_codec dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .data_i     (data_i),
    .last_i     (last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .data_res_o (data_res_o),
    .last_res_o (last_res_o),
    .error_o    (error_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [7:0] b64_symbol(input logic [5:0] v);
    if (v < 6'd26) return 8'h41 + 8'(v);
    if (v < 6'd52) return 8'h61 + 8'(v) - 8'd26;
    if (v < 6'd62) return 8'h30 + 8'(v) - 8'd52;
    if (v == 6'd62) return PlusChar;
    return SlashChar;
  endfunction

  function automatic logic [5:0] b64_value(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) return 6'(c - 8'h41);
    if (c >= 8'h61 && c <= 8'h7A) return 6'(c - 8'h61 + 8'd26);
    if (c >= 8'h30 && c <= 8'h39) return 6'(c - 8'h30 + 8'd52);
    if (c == PlusChar) return 6'd62;
    if (c == SlashChar) return 6'd63;
    return 6'd0;
  endfunction

  function automatic void clear_group();
    grp_bits = '0;
    grp_cnt  = '0;
    pad_3rd  = 1'b0;
  endfunction

  // Advances the predictor by one input word and returns the words it yields.
  function automatic res_set_t codec_step(input logic [7:0] d, input logic l);
    res_set_t   s;
    logic [1:0] cnt;
    int         pads;
    int         drops;
    s   = '0;
    cnt = grp_cnt;
    if (cur_mode == ModeEncode) begin
      if (cnt > 2'd2) cnt = 2'd2;
      grp_bits = grp_bits | ({16'd0, d} << (16 - 8 * cnt));
      if (cnt < 2'd2 && !l) begin
        grp_cnt = cnt + 2'd1;
        return s;
      end
      pads = 2 - cnt;
      s.n  = 3'd4;
      for (int k = 0; k < 4; k++) begin
        s.w[k].data = (k >= 4 - pads) ? PadChar : b64_symbol(grp_bits[23 - 6 * k -: 6]);
        s.w[k].last = (k == 3) ? l : 1'b0;
        s.w[k].err  = 1'b0;
      end
    end else begin
      grp_bits = grp_bits | ({18'd0, b64_value(d)} << (18 - 6 * cnt));
      if (cnt < 2'd3) begin
        if (l) begin
          s.n    = 3'd1;
          s.w[0] = {8'h00, 1'b1, 1'b1};
          clear_group();
          return s;
        end
        if (cnt == 2'd2 && d == PadChar) pad_3rd = 1'b1;
        grp_cnt = cnt + 2'd1;
        return s;
      end
      drops = 0;
      if (l) begin
        if (d == PadChar) drops++;
        if (pad_3rd) drops++;
      end
      s.n = 3'(3 - drops);
      for (int k = 0; k < 3 - drops; k++) begin
        s.w[k].data = grp_bits[23 - 8 * k -: 8];
        s.w[k].last = (k == 2 - drops) ? l : 1'b0;
        s.w[k].err  = 1'b0;
      end
    end
    clear_group();
    return s;
  endfunction

  function automatic res_set_t res_words(input int n, input logic [7:0] d0, input logic [7:0] d1,
                                         input logic [7:0] d2, input logic [7:0] d3,
                                         input logic l, input logic e);
    res_set_t        s;
    logic [3:0][7:0] d;
    s = '0;
    d = {d3, d2, d1, d0};
    s.n = 3'(n);
    for (int k = 0; k < n; k++) begin
      s.w[k].data = d[k];
      s.w[k].last = (k == n - 1) ? l : 1'b0;
      s.w[k].err  = e;
    end
    return s;
  endfunction

  function automatic stim_row_t word_row(input logic [7:0] d, input logic l);
    return {RowWord, 1'b0, d, l, res_set_t'('0)};
  endfunction

  function automatic stim_row_t typed_row(input logic [7:0] d, input logic l, input res_set_t s);
    return {RowWord, 1'b1, d, l, s};
  endfunction

  function automatic stim_row_t cfg_row(input logic m);
    return {RowCfg, 1'b0, {7'd0, m}, 1'b0, res_set_t'('0)};
  endfunction

  task automatic send_word(input logic [7:0] d, input logic l, input logic typed,
                           input res_set_t want);
    int       gap;
    res_set_t got;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_i     <= d;
    last_i     <= l;
    do @(posedge clk_i); while (!in_ready_o);
    n_in++;
    got = codec_step(d, l);
    if (typed) got = want;
    for (int k = 0; k < got.n; k++) exp_q.push_back(got.w[k]);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic m);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_mode = m;
    clear_group();
    n_cfg++;
  endtask

  task automatic rand_message();
    int         len;
    int         groups;
    int         pads;
    logic [7:0] c;
    if (cur_mode == ModeEncode) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        send_word(8'($urandom_range(0, 255)), i == len - 1, 1'b0, '0);
    end else if ($urandom_range(0, 4) == 0) begin
      len = $urandom_range(1, 9);
      for (int i = 0; i < len; i++) begin
        case ($urandom_range(0, 3))
          0:       c = PadChar;
          1:       c = 8'($urandom_range(0, 255));
          default: c = b64_symbol(6'($urandom_range(0, 63)));
        endcase
        send_word(c, i == len - 1, 1'b0, '0);
      end
    end else begin
      groups = $urandom_range(1, 3);
      pads   = $urandom_range(0, 2);
      for (int g = 0; g < groups; g++) begin
        for (int p = 0; p < 4; p++) begin
          c = b64_symbol(6'($urandom_range(0, 63)));
          if (g == groups - 1 && p >= 4 - pads) c = PadChar;
          send_word(c, g == groups - 1 && p == 3, 1'b0, '0);
        end
      end
    end
  endtask

  initial begin : out_side
    @(posedge clk_i);
    forever begin
      ready_hold = calm ? 0 : $urandom_range(0, 3);
      if (ready_hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (ready_hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_out++;
      if (exp_q.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Unexpected result word: data %02h last %0d error %0d",
                   data_res_o, last_res_o, error_o);
      end else begin
        mon_want = exp_q.pop_front();
        if (mon_want != {data_res_o, last_res_o, error_o}) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Mismatch: expected data %02h last %0d error %0d, got data %02h last %0d error %0d",
                     mon_want.data, mon_want.last, mon_want.err,
                     data_res_o, last_res_o, error_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles == QuietLimit) begin
      $display("Watchdog: no word moved for %0d cycles", QuietLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    stim_row_t r;
    int        phase;
    int        n_msg;

    // Encode, starting from the reset mode.
    dir_tab.push_back(typed_row("M", 1'b1, res_words(4, "T", "Q", PadChar, PadChar, 1'b1, 1'b0)));
    dir_tab.push_back(word_row(8'h00, 1'b0));
    dir_tab.push_back(word_row(8'h00, 1'b0));
    dir_tab.push_back(typed_row(8'h00, 1'b0, res_words(4, "A", "A", "A", "A", 1'b0, 1'b0)));
    dir_tab.push_back(word_row(8'hFF, 1'b0));
    dir_tab.push_back(word_row(8'hFF, 1'b0));
    dir_tab.push_back(typed_row(8'hFF, 1'b1, res_words(4, "/", "/", "/", "/", 1'b1, 1'b0)));
    dir_tab.push_back(word_row(8'h12, 1'b0));
    dir_tab.push_back(cfg_row(ModeEncode));
    dir_tab.push_back(typed_row("M", 1'b1, res_words(4, "T", "Q", PadChar, PadChar, 1'b1, 1'b0)));
    dir_tab.push_back(word_row("M", 1'b0));
    dir_tab.push_back(word_row("a", 1'b1));
    // Decode.
    dir_tab.push_back(cfg_row(ModeDecode));
    dir_tab.push_back(word_row("/", 1'b0));
    dir_tab.push_back(word_row("/", 1'b0));
    dir_tab.push_back(word_row("/", 1'b0));
    dir_tab.push_back(typed_row("/", 1'b1, res_words(3, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 1'b0)));
    dir_tab.push_back(word_row(PadChar, 1'b0));
    dir_tab.push_back(word_row("~", 1'b0));
    dir_tab.push_back(word_row(PadChar, 1'b0));
    dir_tab.push_back(word_row(8'h00, 1'b0));
    dir_tab.push_back(word_row("A", 1'b0));
    dir_tab.push_back(word_row("B", 1'b0));
    dir_tab.push_back(cfg_row(ModeDecode));
    dir_tab.push_back(word_row("T", 1'b0));
    dir_tab.push_back(word_row("Q", 1'b0));
    dir_tab.push_back(word_row(PadChar, 1'b0));
    dir_tab.push_back(typed_row(PadChar, 1'b1, res_words(1, 8'h4D, 8'h00, 8'h00, 8'h00, 1'b1, 1'b0)));
    dir_tab.push_back(typed_row("Q", 1'b1, res_words(1, 8'h00, 8'h00, 8'h00, 8'h00, 1'b1, 1'b1)));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      r = dir_tab[i];
      if (r.kind == RowCfg) begin
        settle();
        set_mode(r.data[0]);
      end else begin
        send_word(r.data, r.last, r.typed, r.want);
      end
    end

    phase = 0;
    while (n_in < dir_tab.size() + RandomWords) begin
      settle();
      set_mode(phase[0] ? ModeDecode : ModeEncode);
      calm  = ($urandom_range(0, 3) == 0);
      n_msg = $urandom_range(1, 4);
      for (int m = 0; m < n_msg; m++) rand_message();
      phase++;
    end

    calm = 1'b0;
    settle();
    repeat (8) @(posedge clk_i);

    $display("Ran %0d directed rows and %0d random phases in both modes", dir_tab.size(), phase);
    $display("Sent %0d input words, checked %0d result words, %0d mode writes",
             n_in, n_out, n_cfg);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
